@@ rtl/vdf_pkg.sv @@
// Shared types and constants for the viscous drag force accumulator.
// Holds the cell, result and configuration words plus the queue entry format.
// No dependencies.
`default_nettype none

package vdf_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CFG_W = 32;
	localparam int ACC_W = 48;
	localparam int GSUM_W = VALUE_WIDTH + 2;
	localparam int CFG_IDX_W = 3;

	localparam int SHIFT_Q = 16;
	localparam int SHIFT_HALF = 17;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_DX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_RE = 3'd4;

	localparam logic [CFG_W-1:0] CFG_RESET = 32'h0001_0000;

	// 4/3 and 2/3 in Q16.16, rounded to nearest.
	localparam logic [CFG_W-1:0] K_FOUR_THIRDS = 32'd87381;
	localparam logic [CFG_W-1:0] K_TWO_THIRDS = 32'd43691;

	localparam int FLAG_EAST = 0;
	localparam int FLAG_WEST = 1;
	localparam int FLAG_NORTH = 2;
	localparam int FLAG_SOUTH = 3;
	localparam int FLAG_FLUID = 4;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] u_sw;
		logic signed [VALUE_WIDTH-1:0] u_se;
		logic signed [VALUE_WIDTH-1:0] u_nw;
		logic signed [VALUE_WIDTH-1:0] u_ne;
		logic signed [VALUE_WIDTH-1:0] v_sw;
		logic signed [VALUE_WIDTH-1:0] v_se;
		logic signed [VALUE_WIDTH-1:0] v_nw;
		logic signed [VALUE_WIDTH-1:0] v_ne;
		logic signed [VALUE_WIDTH-1:0] cell_pressure;
		logic [4:0]                    cell_flags;
		logic                          is_last;
	} cell_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] drag_x;
		logic signed [ACC_W-1:0] drag_y;
	} drag_t;

	typedef struct packed {
		logic [CFG_W-1:0] grid_dx;
		logic [CFG_W-1:0] grid_dy;
		logic [CFG_W-1:0] inv_dx;
		logic [CFG_W-1:0] inv_dy;
		logic [CFG_W-1:0] inv_reynolds;
	} cfg_t;

	typedef struct packed {
		logic fluid;
		logic east_sub;
		logic west_add;
		logic north_sub;
		logic south_add;
		logic last;
	} cell_class_t;

	typedef struct packed {
		cell_class_t                   cls;
		logic signed [GSUM_W-1:0]      du_x;
		logic signed [GSUM_W-1:0]      du_y;
		logic signed [GSUM_W-1:0]      dv_x;
		logic signed [GSUM_W-1:0]      dv_y;
		logic signed [VALUE_WIDTH-1:0] pressure;
	} cell_op_t;

endpackage

`default_nettype wire

@@ rtl/vdf_front.sv @@
// Front end: registers an incoming cell, classifies its neighbour flags and
// forms the four corner difference sums. Depends on vdf_pkg.
`default_nettype none

module vdf_front
	import vdf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_t    cell_data,
	input  logic     cell_valid,
	output logic     cell_stall,
	output logic     push,
	output cell_op_t push_data,
	input  logic     full
);

	logic     valid_s1;
	cell_op_t op_s1;
	cell_op_t op_d;
	logic     accept;

	assign push       = valid_s1 & ~full;
	assign cell_stall = valid_s1 & full;
	assign accept     = cell_valid & ~cell_stall;
	assign push_data  = op_s1;

	// East wins over west and north over south, so only one of each pair survives.
	always_comb begin
		op_d.cls.fluid     = cell_data.cell_flags[FLAG_FLUID];
		op_d.cls.east_sub  = cell_data.cell_flags[FLAG_EAST];
		op_d.cls.west_add  = ~cell_data.cell_flags[FLAG_EAST] & cell_data.cell_flags[FLAG_WEST];
		op_d.cls.north_sub = cell_data.cell_flags[FLAG_NORTH];
		op_d.cls.south_add = ~cell_data.cell_flags[FLAG_NORTH]
			& cell_data.cell_flags[FLAG_SOUTH];
		op_d.cls.last      = cell_data.is_last;
		op_d.du_x = GSUM_W'($signed(cell_data.u_ne)) - GSUM_W'($signed(cell_data.u_nw))
			+ GSUM_W'($signed(cell_data.u_se)) - GSUM_W'($signed(cell_data.u_sw));
		op_d.du_y = GSUM_W'($signed(cell_data.u_ne)) + GSUM_W'($signed(cell_data.u_nw))
			- GSUM_W'($signed(cell_data.u_se)) - GSUM_W'($signed(cell_data.u_sw));
		op_d.dv_x = GSUM_W'($signed(cell_data.v_ne)) - GSUM_W'($signed(cell_data.v_nw))
			+ GSUM_W'($signed(cell_data.v_se)) - GSUM_W'($signed(cell_data.v_sw));
		op_d.dv_y = GSUM_W'($signed(cell_data.v_ne)) + GSUM_W'($signed(cell_data.v_nw))
			- GSUM_W'($signed(cell_data.v_se)) - GSUM_W'($signed(cell_data.v_sw));
		op_d.pressure = cell_data.cell_pressure;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/vdf_queue.sv @@
// Short queue of classified cells between the front and back ends.
// Depends on vdf_pkg.
`default_nettype none

module vdf_queue
	import vdf_pkg::*;
#(
	parameter int DEPTH = 4
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cell_op_t push_data,
	output logic     full,
	input  logic     pop,
	output cell_op_t pop_data,
	output logic     empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_op_t         entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/vdf_mulq.sv @@
// One multiplier lane: signed value times unsigned Q16.16 factor, shifted
// right by 16 or 17, truncated toward zero, saturated. Depends on vdf_pkg.
`default_nettype none

module vdf_mulq
	import vdf_pkg::*;
(
	input  logic                    clk,
	input  logic signed [ACC_W-1:0] a,
	input  logic [CFG_W-1:0]        b,
	input  logic                    half,
	output logic signed [ACC_W-1:0] r
);

	localparam int HI_W = ACC_W - CFG_W;
	localparam int HP_W = HI_W + CFG_W;
	localparam int LP_W = 2 * CFG_W;
	localparam int WIDE_W = ACC_W + 2;

	logic [ACC_W-1:0]        mag;
	logic                    neg_s1;
	logic                    half_s1;
	logic [HP_W-1:0]         hi_s1;
	logic [LP_W-1:0]         lo_s1;
	logic [ACC_W-1:0]        cap;
	logic [ACC_W-1:0]        cap_hi;
	logic [ACC_W-1:0]        mag_r;
	logic [WIDE_W-1:0]       r_wide;
	logic signed [ACC_W-1:0] r_s2;

	assign mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
	assign r   = r_s2;

	// Stage 1: the magnitude split into an upper and a lower partial product.
	always_ff @(posedge clk) begin
		neg_s1  <= a[ACC_W-1];
		half_s1 <= half;
		hi_s1   <= HP_W'(mag[ACC_W-1:CFG_W]) * HP_W'(b);
		lo_s1   <= LP_W'(mag[CFG_W-1:0]) * LP_W'(b);
	end

	// Stage 2: recombine, clamp to the signed limit of the sign, restore sign.
	always_comb begin
		cap = neg_s1 ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		if (half_s1) begin
			cap_hi = cap >> (CFG_W - SHIFT_HALF);
			r_wide = (WIDE_W'(hi_s1) << (CFG_W - SHIFT_HALF)) + WIDE_W'(lo_s1 >> SHIFT_HALF);
		end else begin
			cap_hi = cap >> (CFG_W - SHIFT_Q);
			r_wide = (WIDE_W'(hi_s1) << (CFG_W - SHIFT_Q)) + WIDE_W'(lo_s1 >> SHIFT_Q);
		end
		if ((hi_s1 > HP_W'(cap_hi)) || (r_wide > WIDE_W'(cap))) begin
			mag_r = cap;
		end else begin
			mag_r = r_wide[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= neg_s1 ? ACC_W'(-mag_r) : mag_r;
	end

endmodule

`default_nettype wire

@@ rtl/vdf_back.sv @@
// Back end: sequences the four multiplier lanes through the gradient, stress
// and force rounds, keeps the drag totals and holds the result word.
// Depends on vdf_pkg and vdf_mulq.
`default_nettype none

module vdf_back
	import vdf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  cell_op_t op,
	input  logic     empty,
	output logic     pop,
	output drag_t    drag,
	output logic     drag_valid,
	input  logic     drag_stall
);

	localparam int LANES = 4;
	localparam int WIDE_W = ACC_W + 2;
	localparam logic [1:0] PHASE_LAST = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GRAD,
		ST_VISC,
		ST_RE,
		ST_FORCE,
		ST_ACC,
		ST_FIN
	} state_t;

	state_t                        state_q;
	logic [1:0]                    cnt_q;
	cell_class_t                   cls_q;
	logic signed [VALUE_WIDTH-1:0] pres_q;
	logic signed [ACC_W-1:0]       tsum_q;
	logic signed [ACC_W-1:0]       a_q [LANES];
	logic [CFG_W-1:0]              b_q [LANES];
	logic                          half_q;
	logic signed [ACC_W-1:0]       a_d [LANES];
	logic [CFG_W-1:0]              b_d [LANES];
	logic                          half_d;
	logic                          load;
	logic signed [ACC_W-1:0]       r [LANES];
	logic signed [ACC_W-1:0]       sum_x_q;
	logic signed [ACC_W-1:0]       sum_y_q;
	drag_t                         drag_q;
	logic                          drag_valid_q;
	logic signed [ACC_W-1:0]       vx;
	logic signed [ACC_W-1:0]       vy;
	logic signed [ACC_W-1:0]       tsum;
	logic signed [ACC_W-1:0]       sigx;
	logic signed [ACC_W-1:0]       sigy;
	logic signed [ACC_W-1:0]       ew_x;
	logic signed [ACC_W-1:0]       ew_y;
	logic signed [ACC_W-1:0]       ns_x;
	logic signed [ACC_W-1:0]       ns_y;
	logic                          phase_end;
	logic                          out_free;
	logic                          emit;

	function automatic logic signed [WIDE_W-1:0] widen(input logic signed [ACC_W-1:0] x);
		return {{2{x[ACC_W-1]}}, x};
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
		logic [2:0] top;
		top = v[WIDE_W-1:ACC_W-1];
		if (top == 3'b000 || top == 3'b111) begin
			return v[ACC_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			return {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [ACC_W-1:0] acc_step(
		input logic signed [ACC_W-1:0] sum,
		input logic signed [ACC_W-1:0] f,
		input logic                    sub
	);
		return sat_acc(sub ? widen(sum) - widen(f) : widen(sum) + widen(f));
	endfunction

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		vdf_mulq u_lane (
			.clk  (clk),
			.a    (a_q[k]),
			.b    (b_q[k]),
			.half (half_q),
			.r    (r[k])
		);
	end

	assign pop        = (state_q == ST_IDLE) & ~empty;
	assign phase_end  = (cnt_q == PHASE_LAST);
	assign out_free   = ~drag_valid_q | ~drag_stall;
	assign emit       = (state_q == ST_FIN) & cls_q.last & out_free;
	assign drag       = drag_q;
	assign drag_valid = drag_valid_q;

	// Combining steps between multiplier rounds.
	always_comb begin
		tsum = sat_acc(widen(r[2]) + widen(r[1]));
		vx   = sat_acc(widen(r[0]) - widen(r[1]));
		vy   = sat_acc(widen(r[2]) - widen(r[3]));
		sigx = sat_acc(widen(r[0]) - WIDE_W'(pres_q));
		sigy = sat_acc(widen(r[1]) - WIDE_W'(pres_q));
	end

	// The east or west term lands first, then the north or south term.
	always_comb begin
		ew_x = sum_x_q;
		ew_y = sum_y_q;
		ns_x = sum_x_q;
		ns_y = sum_y_q;
		if (cls_q.east_sub || cls_q.west_add) begin
			ew_x = acc_step(sum_x_q, r[0], cls_q.east_sub);
			ew_y = acc_step(sum_y_q, r[1], cls_q.east_sub);
		end
		if (cls_q.north_sub || cls_q.south_add) begin
			ns_x = acc_step(sum_x_q, r[2], cls_q.north_sub);
			ns_y = acc_step(sum_y_q, r[3], cls_q.north_sub);
		end
	end

	always_comb begin
		load   = 1'b0;
		half_d = half_q;
		for (int k = 0; k < LANES; k++) begin
			a_d[k] = a_q[k];
			b_d[k] = b_q[k];
		end
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					load   = 1'b1;
					half_d = 1'b1;
					a_d[0] = ACC_W'($signed(op.du_x));
					a_d[1] = ACC_W'($signed(op.du_y));
					a_d[2] = ACC_W'($signed(op.dv_x));
					a_d[3] = ACC_W'($signed(op.dv_y));
					b_d[0] = cfg.inv_dx;
					b_d[1] = cfg.inv_dy;
					b_d[2] = cfg.inv_dx;
					b_d[3] = cfg.inv_dy;
				end
			end
			ST_GRAD: begin
				if (phase_end) begin
					load   = 1'b1;
					half_d = 1'b0;
					a_d[0] = r[0];
					a_d[1] = r[3];
					a_d[2] = r[3];
					a_d[3] = r[0];
					b_d[0] = K_FOUR_THIRDS;
					b_d[1] = K_TWO_THIRDS;
					b_d[2] = K_FOUR_THIRDS;
					b_d[3] = K_TWO_THIRDS;
				end
			end
			ST_VISC: begin
				if (phase_end) begin
					load   = 1'b1;
					half_d = 1'b0;
					a_d[0] = vx;
					a_d[1] = vy;
					a_d[2] = tsum_q;
					a_d[3] = '0;
					b_d[0] = cfg.inv_reynolds;
					b_d[1] = cfg.inv_reynolds;
					b_d[2] = cfg.inv_reynolds;
					b_d[3] = '0;
				end
			end
			ST_RE: begin
				if (phase_end) begin
					load   = 1'b1;
					half_d = 1'b0;
					a_d[0] = sigx;
					a_d[1] = r[2];
					a_d[2] = r[2];
					a_d[3] = sigy;
					b_d[0] = cfg.grid_dy;
					b_d[1] = cfg.grid_dy;
					b_d[2] = cfg.grid_dx;
					b_d[3] = cfg.grid_dx;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < LANES; k++) begin
				a_q[k] <= a_d[k];
				b_q[k] <= b_d[k];
			end
			half_q <= half_d;
		end
		if (pop) begin
			cls_q  <= op.cls;
			pres_q <= op.pressure;
		end
		if (state_q == ST_GRAD && phase_end) begin
			tsum_q <= tsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			drag_q       <= '0;
			drag_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				drag_valid_q <= 1'b1;
			end else if (drag_valid_q && !drag_stall) begin
				drag_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						cnt_q   <= '0;
						state_q <= op.cls.fluid ? ST_GRAD : ST_FIN;
					end
				end
				ST_GRAD: begin
					cnt_q <= phase_end ? '0 : cnt_q + 1'b1;
					if (phase_end) begin
						state_q <= ST_VISC;
					end
				end
				ST_VISC: begin
					cnt_q <= phase_end ? '0 : cnt_q + 1'b1;
					if (phase_end) begin
						state_q <= ST_RE;
					end
				end
				ST_RE: begin
					cnt_q <= phase_end ? '0 : cnt_q + 1'b1;
					if (phase_end) begin
						state_q <= ST_FORCE;
					end
				end
				ST_FORCE: begin
					cnt_q <= phase_end ? '0 : cnt_q + 1'b1;
					if (phase_end) begin
						sum_x_q <= ew_x;
						sum_y_q <= ew_y;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_x_q <= ns_x;
					sum_y_q <= ns_y;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!cls_q.last) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						drag_q.drag_x <= sum_x_q;
						drag_q.drag_y <= sum_y_q;
						sum_x_q       <= '0;
						sum_y_q       <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/viscous_drag_force_accumulator_top.sv @@
// Top level of the viscous drag force accumulator: configuration registers,
// front end, cell queue and back end. Depends on vdf_pkg, vdf_front,
// vdf_queue and vdf_back.
//
// Channel  Dir  Handshake                Word
// cell     in   cell_valid / cell_stall  cell_data (cell_t): corner u and v, pressure, flags,
//                                        last mark
// drag     out  drag_valid / drag_stall  drag_t: x and y drag totals, Q32.16
// cfg      in   cfg_write                cfg_index selects the register, cfg_data is the value
//
// The front end registers a cell and passes it into a queue of QUEUE_DEPTH
// entries, so cells are taken while the back end is busy.
// The back end takes a cell's word from the queue. For a fluid cell its four shared
// multiplier lanes then run four dependent rounds (gradients, 4/3 and 2/3 scaling,
// 1/Re, cell size), the last of which also adds the east or west term; it then adds
// the north or south term and finishes the cell. Any other cell goes straight to
// the finish.
// Reset is asynchronous and active low; it clears both totals and sets every
// register to 1.0. A stalled result word holds, and a last cell waits in the back
// end until the word is free; cell_stall rises when a held cell meets a full queue.
`default_nettype none

module viscous_drag_force_accumulator_top
	import vdf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  cell_t                cell_data,
	input  logic                 cell_valid,
	output logic                 cell_stall,
	output drag_t                drag,
	output logic                 drag_valid,
	input  logic                 drag_stall
);

	cfg_t     cfg_q;
	logic     push;
	cell_op_t push_data;
	logic     full;
	logic     pop;
	cell_op_t pop_data;
	logic     empty;

	// Registers are to be written by the user only while the block is idle; the block
	// itself does not enforce this. Unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_dx      <= CFG_RESET;
			cfg_q.grid_dy      <= CFG_RESET;
			cfg_q.inv_dx       <= CFG_RESET;
			cfg_q.inv_dy       <= CFG_RESET;
			cfg_q.inv_reynolds <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GRID_DX: cfg_q.grid_dx      <= cfg_data;
				REG_GRID_DY: cfg_q.grid_dy      <= cfg_data;
				REG_INV_DX:  cfg_q.inv_dx       <= cfg_data;
				REG_INV_DY:  cfg_q.inv_dy       <= cfg_data;
				REG_INV_RE:  cfg_q.inv_reynolds <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end classifies each cell and forms its difference sums.
	vdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_data  (cell_data),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	// The queue lets the front end keep taking cells while the back end works.
	vdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// The back end evaluates stresses, updates the totals and emits on a last cell.
	vdf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.op         (pop_data),
		.empty      (empty),
		.pop        (pop),
		.drag       (drag),
		.drag_valid (drag_valid),
		.drag_stall (drag_stall)
	);

endmodule

`default_nettype wire

@@ rtl/vdf_checker.sv @@
// Port-level checks for the viscous drag force accumulator, bound to the top
// level. Depends on vdf_pkg.
`default_nettype none

module vdf_checker
	import vdf_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  cell_valid,
	input logic  cell_stall,
	input drag_t drag,
	input logic  drag_valid,
	input logic  drag_stall
);

	// Coming out of reset, no result is offered and cells are not held off.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !drag_valid && !cell_stall)
		else $error("result or stall present straight after reset");

	// The input can only back up right after a cell has been taken.
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cell_stall) |-> $past(cell_valid && !cell_stall))
		else $error("cell_stall rose without a cell taken the cycle before");

	// A stalled result word stays offered and unchanged.
	a_drag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drag_valid && drag_stall |=> drag_valid && $stable(drag))
		else $error("stalled result word changed or was withdrawn");

endmodule

bind viscous_drag_force_accumulator_top vdf_checker u_vdf_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for viscous_drag_force_accumulator_top: directed cells, then random passes.
// Depends on vdf_pkg and the top level only; every drag word is checked against a local predictor or a table value.

module tb;
	import vdf_pkg::*;

	// The clock period is 12 ns. The timeout and the settling pause are counted in clock cycles.
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_COUNT = 7;
	localparam int PASS_ITEMS = 100;
	localparam int MAX_PRINTED = 30;

	// Register indexes above the last real one are decoded as nothing.
	localparam int REG_SPARE_FIRST = 5;
	localparam int REG_SPARE_LAST = 7;

	// Masks of the cell flags, built from the bit positions in the package.
	localparam logic [4:0] F_EAST = 5'(1 << FLAG_EAST);
	localparam logic [4:0] F_WEST = 5'(1 << FLAG_WEST);
	localparam logic [4:0] F_NORTH = 5'(1 << FLAG_NORTH);
	localparam logic [4:0] F_SOUTH = 5'(1 << FLAG_SOUTH);
	localparam logic [4:0] F_FLUID = 5'(1 << FLAG_FLUID);

	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	typedef struct {
		cell_t c;
		bit    typed;
		drag_t want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	cell_t                cell_data;
	logic                 cell_valid;
	logic                 cell_stall;
	drag_t                drag;
	logic                 drag_valid;
	logic                 drag_stall;

	// Predictor state: a shadow of the registers and the two running drag totals.
	cfg_t   shadow_regs;
	longint drag_sum_x;
	longint drag_sum_y;

	// Drag words still owed by the block, oldest first.
	drag_t pending_drag[$];

	// The row being offered: when typed, its drag word is taken from the table.
	bit    row_typed;
	drag_t row_want;

	// Idling control shared between the sender, the receiver and the main sequence.
	bit idle_on;
	bit hold_req;
	int stall_left;

	int error_count;
	int cycle_count;
	int cells_taken;
	int drags_checked;

	stim_row_t directed[$];

	viscous_drag_force_accumulator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cell_data(cell_data),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.drag(drag),
		.drag_valid(drag_valid),
		.drag_stall(drag_stall)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Clamp to the 48-bit signed range of the accumulators.
	function automatic longint clamp48(input longint v);
		if (v > ACC_MAX) return ACC_MAX;
		if (v < ACC_MIN) return ACC_MIN;
		return v;
	endfunction

	// Signed value times an unsigned Q16.16 factor, shifted right by s with truncation
	// towards zero, then clamped to 48 bits. The product is formed on 96 bits so that
	// nothing is lost before the shift.
	function automatic longint scale_q(input longint a, input logic [31:0] b, input int s);
		logic [95:0] mag;
		logic [95:0] prod;
		logic [95:0] cap;
		bit          neg;
		neg = (a < 0);
		mag = neg ? 96'(-a) : 96'(a);
		prod = (mag * {64'd0, b}) >> s;
		cap = neg ? (96'd1 << 47) : ((96'd1 << 47) - 96'd1);
		if (prod > cap)
			prod = cap;
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	// Folds one cell into the drag totals and, on a last cell, hands back the totals and
	// clears them.
	task automatic accumulate_cell(input cell_t c, output bit emitted, output drag_t totals);
		longint usw, use_, unw, une, vsw, vse, vnw, vne, p;
		longint du_x, du_y, dv_x, dv_y, vis_x, vis_y, sig_x, sig_y, tau;
		usw = longint'($signed(c.u_sw));
		use_ = longint'($signed(c.u_se));
		unw = longint'($signed(c.u_nw));
		une = longint'($signed(c.u_ne));
		vsw = longint'($signed(c.v_sw));
		vse = longint'($signed(c.v_se));
		vnw = longint'($signed(c.v_nw));
		vne = longint'($signed(c.v_ne));
		p = longint'($signed(c.cell_pressure));
		if (c.cell_flags[FLAG_FLUID]) begin
			du_x = scale_q(une - unw + use_ - usw, shadow_regs.inv_dx, SHIFT_HALF);
			du_y = scale_q(une + unw - use_ - usw, shadow_regs.inv_dy, SHIFT_HALF);
			dv_x = scale_q(vne - vnw + vse - vsw, shadow_regs.inv_dx, SHIFT_HALF);
			dv_y = scale_q(vne + vnw - vse - vsw, shadow_regs.inv_dy, SHIFT_HALF);
			vis_x = clamp48(scale_q(du_x, K_FOUR_THIRDS, SHIFT_Q)
				- scale_q(dv_y, K_TWO_THIRDS, SHIFT_Q));
			vis_y = clamp48(scale_q(dv_y, K_FOUR_THIRDS, SHIFT_Q)
				- scale_q(du_x, K_TWO_THIRDS, SHIFT_Q));
			sig_x = clamp48(-p + scale_q(vis_x, shadow_regs.inv_reynolds, SHIFT_Q));
			sig_y = clamp48(-p + scale_q(vis_y, shadow_regs.inv_reynolds, SHIFT_Q));
			tau = scale_q(clamp48(dv_x + du_y), shadow_regs.inv_reynolds, SHIFT_Q);
			// East wins over west, and north over south.
			if (c.cell_flags[FLAG_EAST]) begin
				drag_sum_x = clamp48(drag_sum_x - scale_q(sig_x, shadow_regs.grid_dy, SHIFT_Q));
				drag_sum_y = clamp48(drag_sum_y - scale_q(tau, shadow_regs.grid_dy, SHIFT_Q));
			end else if (c.cell_flags[FLAG_WEST]) begin
				drag_sum_x = clamp48(drag_sum_x + scale_q(sig_x, shadow_regs.grid_dy, SHIFT_Q));
				drag_sum_y = clamp48(drag_sum_y + scale_q(tau, shadow_regs.grid_dy, SHIFT_Q));
			end
			if (c.cell_flags[FLAG_NORTH]) begin
				drag_sum_x = clamp48(drag_sum_x - scale_q(tau, shadow_regs.grid_dx, SHIFT_Q));
				drag_sum_y = clamp48(drag_sum_y - scale_q(sig_y, shadow_regs.grid_dx, SHIFT_Q));
			end else if (c.cell_flags[FLAG_SOUTH]) begin
				drag_sum_x = clamp48(drag_sum_x + scale_q(tau, shadow_regs.grid_dx, SHIFT_Q));
				drag_sum_y = clamp48(drag_sum_y + scale_q(sig_y, shadow_regs.grid_dx, SHIFT_Q));
			end
		end
		emitted = c.is_last;
		totals.drag_x = drag_sum_x[ACC_W-1:0];
		totals.drag_y = drag_sum_y[ACC_W-1:0];
		if (c.is_last) begin
			drag_sum_x = 0;
			drag_sum_y = 0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// All sampling happens at the rising edge, where the payloads driven at the falling
	// edge are stable. A drag word is checked before any cell taken at the same edge is
	// predicted, since a cell can never produce its word in the cycle it is taken.
	always @(posedge clk) begin
		bit    emitted;
		drag_t totals;
		drag_t want;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					REG_GRID_DX: shadow_regs.grid_dx = cfg_data;
					REG_GRID_DY: shadow_regs.grid_dy = cfg_data;
					REG_INV_DX:  shadow_regs.inv_dx = cfg_data;
					REG_INV_DY:  shadow_regs.inv_dy = cfg_data;
					REG_INV_RE:  shadow_regs.inv_reynolds = cfg_data;
					default: ;
				endcase
			end
			if (drag_valid && !drag_stall) begin
				drags_checked++;
				if (pending_drag.size() == 0) begin
					report_mismatch($sformatf("drag word x=%h y=%h with none owed",
						drag.drag_x, drag.drag_y));
				end else begin
					want = pending_drag.pop_front();
					if (drag.drag_x !== want.drag_x)
						report_mismatch($sformatf("drag_x got %h, wanted %h",
							drag.drag_x, want.drag_x));
					if (drag.drag_y !== want.drag_y)
						report_mismatch($sformatf("drag_y got %h, wanted %h",
							drag.drag_y, want.drag_y));
				end
			end
			if (cell_valid && !cell_stall) begin
				cells_taken++;
				accumulate_cell(cell_data, emitted, totals);
				if (emitted)
					pending_drag.push_back(row_typed ? row_want : totals);
			end
		end
	end

	// A hung handshake must not hold the run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver decides its stall at every falling edge. A requested hold is counted
	// here, so the sender can keep offering cells while the result side is blocked.
	initial begin
		int r;
		drag_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				drag_stall = 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				drag_stall = 1'b1;
			end else if (!idle_on) begin
				drag_stall = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					drag_stall = 1'b0;
				end else begin
					stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(9, 39);
					drag_stall = 1'b1;
				end
			end
		end
	end

	// Mostly no gap, sometimes a short one and now and then a long one.
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one cell word after an optional gap and returns at the edge that takes it.
	// Each falling edge carries a single assignment to cell_valid, so back-to-back words
	// keep valid high throughout.
	task automatic send_cell(input cell_t c, input bit typed, input drag_t want);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			cell_valid = 1'b0;
		end
		@(negedge clk);
		cell_data = c;
		row_typed = typed;
		row_want = want;
		cell_valid = 1'b1;
		do
			@(posedge clk);
		while (cell_stall);
	endtask

	// Stops offering, waits for every owed drag word and then lets the back end finish
	// any non-last cells still in flight.
	task automatic drain_cells();
		@(negedge clk);
		cell_valid = 1'b0;
		while (pending_drag.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
	endtask

	// Writes all five registers and, when asked, the unused indexes too.
	task automatic load_regs(input logic [31:0] dx, input logic [31:0] dy,
			input logic [31:0] idx, input logic [31:0] idy, input logic [31:0] ire,
			input bit spare);
		int k;
		write_reg(REG_GRID_DX, dx);
		write_reg(REG_GRID_DY, dy);
		write_reg(REG_INV_DX, idx);
		write_reg(REG_INV_DY, idy);
		write_reg(REG_INV_RE, ire);
		if (spare) begin
			for (k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
				write_reg(CFG_IDX_W'(k), $urandom());
		end
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Field values: extremes, full-range noise, and moderate values near unity that keep
	// the stresses clear of saturation.
	function automatic logic [31:0] rand_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return 32'd0;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r <= 2)
			return $urandom();
		return 32'($urandom_range(0, 1 << 21)) - 32'h0010_0000;
	endfunction

	function automatic logic [31:0] rand_reg();
		if ($urandom_range(0, 1) == 0)
			return 32'($urandom_range(1 << 12, 1 << 20));
		return $urandom() | 32'd1;
	endfunction

	// A well-formed cell is fluid nine times in ten; a noise cell has any flags at all.
	function automatic cell_t rand_cell(input bit well_formed);
		cell_t c;
		c.u_sw = rand_value();
		c.u_se = rand_value();
		c.u_nw = rand_value();
		c.u_ne = rand_value();
		c.v_sw = rand_value();
		c.v_se = rand_value();
		c.v_nw = rand_value();
		c.v_ne = rand_value();
		c.cell_pressure = rand_value();
		if (well_formed)
			c.cell_flags = {($urandom_range(0, 9) != 0), 4'($urandom())};
		else
			c.cell_flags = 5'($urandom());
		c.is_last = 1'b0;
		return c;
	endfunction

	// Random passes over a strip of cells, each closed by a last cell, mixed with noise.
	// Only cells that can move the totals or release them count towards n.
	task automatic run_passes(input int n);
		int    count;
		int    len;
		int    k;
		cell_t c;
		drag_t none;
		none = '0;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 9) < 8) begin
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++) begin
					c = rand_cell(1'b1);
					c.is_last = (k == len - 1);
					send_cell(c, 1'b0, none);
					if (c.cell_flags[FLAG_FLUID] || c.is_last)
						count++;
				end
			end else begin
				c = rand_cell(1'b0);
				c.is_last = ($urandom_range(0, 3) == 0);
				send_cell(c, 1'b0, none);
				if (c.cell_flags[FLAG_FLUID] || c.is_last)
					count++;
			end
		end
	endtask

	// A cell at rest, so that only the pressure and the flags matter.
	function automatic cell_t still_cell(input logic [31:0] p, input logic [4:0] flags,
			input logic last);
		cell_t c;
		c = '0;
		c.cell_pressure = p;
		c.cell_flags = flags;
		c.is_last = last;
		return c;
	endfunction

	function automatic cell_t flow_cell(input logic [31:0] usw, input logic [31:0] use_,
			input logic [31:0] unw, input logic [31:0] une, input logic [31:0] vsw,
			input logic [31:0] vse, input logic [31:0] vnw, input logic [31:0] vne,
			input logic [31:0] p, input logic [4:0] flags, input logic last);
		cell_t c;
		c.u_sw = usw;
		c.u_se = use_;
		c.u_nw = unw;
		c.u_ne = une;
		c.v_sw = vsw;
		c.v_se = vse;
		c.v_nw = vnw;
		c.v_ne = vne;
		c.cell_pressure = p;
		c.cell_flags = flags;
		c.is_last = last;
		return c;
	endfunction

	task automatic add_row(input cell_t c, input bit typed, input longint wx, input longint wy);
		stim_row_t row;
		row.c = c;
		row.typed = typed;
		row.want.drag_x = wx[ACC_W-1:0];
		row.want.drag_y = wy[ACC_W-1:0];
		directed.push_back(row);
	endtask

	// Directed cells under the reset registers, where every factor is one. With the fluid
	// at rest, sigma is minus the pressure and tau is zero, so a pressure of one gives a
	// drag of plus or minus one on the axis of the surface side.
	task automatic build_directed();
		// A non-fluid cell contributes nothing, whatever its neighbour bits say.
		add_row(still_cell(Q_ONE, F_EAST | F_WEST | F_NORTH | F_SOUTH, 1'b1), 1'b1, 0, 0);
		add_row(still_cell(Q_ONE, F_FLUID | F_EAST, 1'b1), 1'b1, 65536, 0);
		add_row(still_cell(Q_ONE, F_FLUID | F_WEST, 1'b1), 1'b1, -65536, 0);
		add_row(still_cell(Q_ONE, F_FLUID | F_NORTH, 1'b1), 1'b1, 0, 65536);
		add_row(still_cell(Q_ONE, F_FLUID | F_SOUTH, 1'b1), 1'b1, 0, -65536);
		// Both sides set: east beats west and north beats south.
		add_row(still_cell(Q_ONE, F_FLUID | F_EAST | F_WEST, 1'b1), 1'b1, 65536, 0);
		add_row(still_cell(Q_ONE, F_FLUID | F_NORTH | F_SOUTH, 1'b1), 1'b1, 0, 65536);
		add_row(still_cell(Q_ONE, F_FLUID | F_EAST | F_NORTH, 1'b1), 1'b1, 65536, 65536);
		// Two cells build up, and a non-fluid last cell still releases and clears them.
		add_row(still_cell(Q_ONE, F_FLUID | F_EAST, 1'b0), 1'b0, 0, 0);
		add_row(still_cell(Q_ONE, F_FLUID | F_EAST, 1'b0), 1'b0, 0, 0);
		add_row(still_cell(Q_ONE, 5'd0, 1'b1), 1'b1, 131072, 0);
		add_row(still_cell(Q_ONE, F_FLUID, 1'b1), 1'b1, 0, 0);
		// The rest, mostly with moving fluid, are left to the predictor.
		add_row(flow_cell(0, 2 * Q_ONE, 0, 2 * Q_ONE, 0, 0, 0, 0, 0,
			F_FLUID | F_EAST | F_NORTH, 1'b1), 1'b0, 0, 0);
		add_row(flow_cell(0, 0, 0, 0, 0, Q_ONE, 0, Q_ONE, Q_ONE,
			F_FLUID | F_NORTH, 1'b1), 1'b0, 0, 0);
		add_row(flow_cell(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX,
			5'h1F, 1'b1), 1'b0, 0, 0);
		add_row(flow_cell(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN,
			F_FLUID | F_WEST | F_SOUTH, 1'b1), 1'b0, 0, 0);
		add_row(flow_cell(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0,
			F_FLUID | F_EAST | F_SOUTH, 1'b1), 1'b0, 0, 0);
		add_row(flow_cell('1, '1, '1, '1, '1, '1, '1, '1, '1,
			F_FLUID | F_WEST | F_NORTH, 1'b1), 1'b0, 0, 0);
		add_row(still_cell(Q_MAX, F_FLUID | F_EAST, 1'b0), 1'b0, 0, 0);
		add_row(still_cell(Q_MIN, F_FLUID | F_WEST, 1'b1), 1'b0, 0, 0);
	endtask

	initial begin
		int    ph;
		int    k;
		cell_t c;
		drag_t none;
		none = '0;
		// Every input has a known value from time zero, and reset is held from the start.
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cell_data = '0;
		cell_valid = 1'b0;
		row_typed = 1'b0;
		row_want = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		error_count = 0;
		cycle_count = 0;
		cells_taken = 0;
		drags_checked = 0;
		shadow_regs = {5{CFG_RESET}};
		drag_sum_x = 0;
		drag_sum_y = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		build_directed();
		foreach (directed[i])
			send_cell(directed[i].c, directed[i].typed, directed[i].want);
		drain_cells();

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: load_regs(32'h0000_8000, 32'h0002_0000, 32'h0002_0000, 32'h0000_8000,
					32'd655, 1'b0);
				// The widest registers drive the stresses and the totals into saturation.
				1: load_regs('1, '1, '1, '1, '1, 1'b0);
				2: load_regs(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0);
				// A zero register is taken as written and zeroes every product with it;
				// writes to the unused indexes must leave the registers alone.
				3: load_regs(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'd0, 1'b1);
				default: load_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
					1'b0);
			endcase
			idle_on = (ph != 0) && (ph != 2);
			if (ph == 0) begin
				// The receiver holds off for a long stretch while cells keep coming, so
				// the queue fills up and the input is stalled.
				hold_req = 1'b1;
				for (k = 0; k < 30; k++) begin
					c = rand_cell(1'b1);
					c.is_last = (k % 3 == 2);
					send_cell(c, 1'b0, none);
				end
			end
			if (ph == 4) begin
				// The sender pauses mid-phase until every owed word has come back.
				run_passes(PASS_ITEMS / 2);
				drain_cells();
				run_passes(PASS_ITEMS / 2);
			end else begin
				run_passes(PASS_ITEMS);
			end
			drain_cells();
		end

		$display("Run covered %0d cells and %0d drag words over %0d register settings.",
			cells_taken, drags_checked, PHASE_COUNT + 1);
		$display("It included directed surface cases, saturation extremes and a long result hold.");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
